>>> rtl/ccbu_pkg.sv
// ----------------------------------------------------------------------------
// ccbu_pkg
// Types, widths and constants shared by the centre-crop 2x upscaler.
// ----------------------------------------------------------------------------
package ccbu_pkg;

  // line buffer geometry
  localparam int MAX_LINE_WIDTH = 2048;
  localparam int PIXEL_BITS     = 8;
  localparam int COL_W          = $clog2(MAX_LINE_WIDTH);      // line buffer index
  localparam int WID_W          = $clog2(MAX_LINE_WIDTH + 1);  // holds the width itself
  localparam int XW             = COL_W - 1;                   // window column offset

  // frame height limits
  localparam int MAX_FRAME_HEIGHT = 4096;
  localparam int ROW_W            = 12;
  localparam int HGT_W            = 13;
  localparam int YW               = 11;

  // register widths and resets
  localparam int FW_W        = 12;
  localparam int FH_W        = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 12'd1920;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
  localparam int MIN_SIZE = 4;

  // output field widths
  localparam int OCOL_W = 11;
  localparam int OROW_W = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // pixel type
  typedef logic [PIXEL_BITS-1:0] pix_t;

  // which of the four results of a neighbourhood is being sent
  typedef enum logic [1:0] {
    PH_CORNER = 2'd0,
    PH_HORIZ  = 2'd1,
    PH_VERT   = 2'd2,
    PH_MEAN   = 2'd3
  } phase_t;

endpackage

>>> rtl/ccbu_pix_if.sv
// ----------------------------------------------------------------------------
// ccbu_pix_if
// Source pixel channel: valid/ready with one grey pixel per beat.
// ----------------------------------------------------------------------------
interface ccbu_pix_if;
  import ccbu_pkg::*;

  logic valid;
  logic ready;
  pix_t pixel_value;
  logic frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

>>> rtl/ccbu_res_if.sv
// ----------------------------------------------------------------------------
// ccbu_res_if
// Result channel: valid/ready with one zoomed pixel and its position per beat.
// ----------------------------------------------------------------------------
interface ccbu_res_if;
  import ccbu_pkg::*;

  logic              valid;
  logic              ready;
  logic [OCOL_W-1:0] out_column;
  logic [OROW_W-1:0] out_row;
  pix_t              out_value;
  logic              last_of_group;

  modport source (output valid, output out_column, output out_row, output out_value,
                  output last_of_group, input ready);
  modport sink   (input valid, input out_column, input out_row, input out_value,
                  input last_of_group, output ready);
endinterface

>>> rtl/ccbu_ram.sv
// ----------------------------------------------------------------------------
// ccbu_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module ccbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/center_crop_bilinear_upscale_2x_core.sv
// ----------------------------------------------------------------------------
// center_crop_bilinear_upscale_2x_core
// 2x digital zoom on the frame centre by bilinear interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   in_pix takes grey source pixels in raster order, one per beat;
//   frame_start on a beat puts that pixel at row 0, column 0.
//   out_res gives, for each source pixel that closes a 2x2 neighbourhood
//   inside the centre window, four beats: corner, horizontal average,
//   vertical average, four-pixel mean; last_of_group marks the fourth.
//   cfg_we/cfg_index/cfg_data write frame_width (0) and frame_height (1);
//   write only while the block is idle.
// Timing:
//   An accepted pixel passes the result stage and the output register before
//   its first result is valid. A window pixel holds the result stage for its
//   four beats (one a cycle on the single result channel, unless out_res
//   stalls); any other pixel retires at once. The line buffer is a one-read
//   one-write RAM, read and written at the pixel's column in the accept cycle.
// Reset and stall:
//   Synchronous rst_n clears position, neighbour pixels and the pipeline;
//   the line buffer is not cleared. While out_res is stalled the held beat
//   stays put, one further window pixel waits in the result stage, and
//   pixels outside the window pass only until a window pixel holds that stage.
// ----------------------------------------------------------------------------
module center_crop_bilinear_upscale_2x_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ccbu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ccbu_pkg::CFG_DATA_W-1:0]  cfg_data,
  ccbu_pix_if.sink                         in_pix,
  ccbu_res_if.source                       out_res
);
  import ccbu_pkg::*;

  // configuration
  logic [FW_W-1:0]  frame_width_r;
  logic [FH_W-1:0]  frame_height_r;

  // position of the next pixel and neighbour pixels
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  pix_t             prev_cur_r;    // pixel (r, c-1)
  pix_t             prev_prev_r;   // pixel (r-1, c-1)

  // result stage
  logic             s1_valid_r;
  logic             s1_win_r;
  pix_t             s1_d_r;
  pix_t             s1_cl_r;
  logic [XW-1:0]    s1_x_r;
  logic [YW-1:0]    s1_y_r;
  phase_t           ph_r;
  pix_t             ram_b;

  // output register
  logic              out_valid_r;
  logic [OCOL_W-1:0] out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;
  pix_t              out_val_r, out_val_nxt;
  logic              out_last_r;

  // step logic
  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [WID_W-1:0] c0, c1, cn, sx, x0;
  logic [WID_W:0]   xlim;
  logic [HGT_W-1:0] r0, r1, r2, rn, sy, y0, ylim;
  logic             win;
  logic [WID_W-1:0] x_full;
  logic [HGT_W-1:0] y_full;

  logic accept, load_out, retire;
  logic [PIXEL_BITS:0]   sum2;
  logic [PIXEL_BITS+1:0] sum4;
  logic                  lsb_col, lsb_row;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame sizes
  always_comb begin
    if (32'(frame_width_r) < MIN_SIZE) begin
      w_eff = WID_W'(MIN_SIZE);
    end else if (32'(frame_width_r) > MAX_LINE_WIDTH) begin
      w_eff = WID_W'(MAX_LINE_WIDTH);
    end else begin
      w_eff = WID_W'(frame_width_r);
    end
    if (32'(frame_height_r) < MIN_SIZE) begin
      h_eff = HGT_W'(MIN_SIZE);
    end else if (32'(frame_height_r) > MAX_FRAME_HEIGHT) begin
      h_eff = HGT_W'(MAX_FRAME_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
  end

  // position of this pixel, window test and next position
  always_comb begin
    c0 = in_pix.frame_start ? '0 : WID_W'(col_r);
    r0 = in_pix.frame_start ? '0 : HGT_W'(row_r);
    // column left beyond a narrowed line: start the next row
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + HGT_W'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= h_eff) ? '0 : r1;

    sx   = c1 - WID_W'(1);
    sy   = r2 - HGT_W'(1);
    x0   = w_eff >> 2;
    y0   = h_eff >> 2;
    xlim = {1'b0, x0} + {2'b0, w_eff[WID_W-1:1]};
    ylim = y0 + (h_eff >> 1);
    win  = (r2 != '0) && (c1 != '0) && (sy >= y0) && (sy < ylim) &&
           (sx >= x0) && ({1'b0, sx} < xlim);
    x_full = sx - x0;
    y_full = sy - y0;

    // advance, wrapping at line and frame end
    cn = c1 + WID_W'(1);
    rn = r2 + HGT_W'(1);
    if (cn >= w_eff) begin
      col_nxt = '0;
      row_nxt = (rn >= h_eff) ? '0 : rn[ROW_W-1:0];
    end else begin
      col_nxt = cn[COL_W-1:0];
      row_nxt = r2[ROW_W-1:0];
    end
  end

  // handshake control
  assign load_out     = s1_valid_r && s1_win_r && (!out_valid_r || out_res.ready);
  assign retire       = s1_valid_r && (!s1_win_r || (load_out && ph_r == PH_MEAN));
  assign in_pix.ready = !s1_valid_r || retire;
  assign accept       = in_pix.valid && in_pix.ready;

  // line buffer: previous row, read old value and write new one at c
  ccbu_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (c1[COL_W-1:0]),
    .wr_data (in_pix.pixel_value),
    .rd_en   (accept),
    .rd_addr (c1[COL_W-1:0]),
    .rd_data (ram_b)
  );

  // position and neighbour state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      prev_cur_r  <= '0;
      prev_prev_r <= '0;
    end else begin
      if (accept) begin
        col_r      <= col_nxt;
        row_r      <= row_nxt;
        prev_cur_r <= in_pix.pixel_value;
      end
      // the line buffer word of the retiring pixel is the next corner
      if (retire) begin
        prev_prev_r <= ram_b;
      end
    end
  end

  // result stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      ph_r       <= PH_CORNER;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (retire) begin
        s1_valid_r <= 1'b0;
      end
      if (accept) begin
        ph_r <= PH_CORNER;
      end else if (load_out) begin
        ph_r <= phase_t'(ph_r + 2'd1);
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_win_r <= win;
      s1_d_r   <= in_pix.pixel_value;
      s1_cl_r  <= prev_cur_r;
      s1_x_r   <= x_full[XW-1:0];
      s1_y_r   <= y_full[YW-1:0];
    end
  end

  // interpolated beat for the current phase
  always_comb begin
    sum2    = '0;
    sum4    = {2'b0, prev_prev_r} + {2'b0, ram_b} + {2'b0, s1_cl_r} + {2'b0, s1_d_r};
    lsb_col = (ph_r == PH_HORIZ) || (ph_r == PH_MEAN);
    lsb_row = (ph_r == PH_VERT) || (ph_r == PH_MEAN);
    case (ph_r)
      PH_CORNER: out_val_nxt = prev_prev_r;
      PH_HORIZ: begin
        sum2        = {1'b0, prev_prev_r} + {1'b0, ram_b};
        out_val_nxt = sum2[PIXEL_BITS:1];
      end
      PH_VERT: begin
        sum2        = {1'b0, prev_prev_r} + {1'b0, s1_cl_r};
        out_val_nxt = sum2[PIXEL_BITS:1];
      end
      PH_MEAN:   out_val_nxt = sum4[PIXEL_BITS+1:2];
      default:   out_val_nxt = prev_prev_r;
    endcase
    out_col_nxt = OCOL_W'({s1_x_r, lsb_col});
    out_row_nxt = OROW_W'({s1_y_r, lsb_row});
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      out_val_r  <= out_val_nxt;
      out_last_r <= (ph_r == PH_MEAN);
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.out_column    = out_col_r;
  assign out_res.out_row       = out_row_r;
  assign out_res.out_value     = out_val_r;
  assign out_res.last_of_group = out_last_r;

`ifndef NO_ASSERTIONS
  // no new pixel while a neighbourhood still has beats to send
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_win_r && ph_r != PH_MEAN) |-> !in_pix.ready)
    else $error("pixel accepted before its predecessor's results were sent");

  // a beat that is not the last of its group keeps its pixel in the result stage
  a_group_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (s1_valid_r && s1_win_r))
    else $error("result group broken off before its last beat");

  // past the first phase the earlier beat is still in the output register
  a_phase_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_win_r && ph_r != PH_CORNER) |-> out_valid_r)
    else $error("phase advanced without a beat in the output register");

  // an accepted pixel always lands in the result stage
  a_accept_land: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted pixel lost");
`endif

endmodule
